@@ sv/cmbp_pkg.sv @@
// Shared types, codes and constants for the context model bit predictor.
package cmbp_pkg;

  // Default sizes
  localparam int unsigned DefBufferBytes  = 8192;
  localparam int unsigned DefTableEntries = 65536;
  localparam int unsigned DefContextBytes = 32;

  // Hash multiplier for the first probe slot
  localparam logic [31:0] HashMult  = 32'h9E37_79B1;
  // Known high bits mask source, shifted right by the bit index
  localparam logic [15:0] KnownBase = 16'hFF00;
  localparam logic [7:0]  CntMax    = 8'd255;
  localparam int unsigned BoostSh   = 2;

  typedef enum logic [1:0] {
    ACT_CODE    = 2'd0,
    ACT_PRELOAD = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic {
    CFG_MASK = 1'b0,
    CFG_SAT  = 1'b1
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic accept_clear;
    logic accept_preload;
    logic accept_code;
    logic clr_step;
    logic do_hash;
    logic tab_read;
    logic ctx_init;
    logic ctx_issue;
    logic next_slot;
    logic finish;
    logic fin_found;
    logic fin_hist;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic buf_full;
    logic ent_valid;
    logic last_j;
    logic mism;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/cmbp_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cmbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cmbp_ctrl.sv @@
// Controller state machine: sequences table clearing, hashing, probing, context compare and update.
module cmbp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      action_i,
  output logic            in_stall_o,
  input  cmbp_pkg::sts_t  sts_i,
  output cmbp_pkg::cmd_t  cmd_o
);
  import cmbp_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_HASH     = 11'b000_0000_0100,
    S_READ     = 11'b000_0000_1000,
    S_CHECK    = 11'b000_0001_0000,
    S_CTX      = 11'b000_0010_0000,
    S_CTX_END  = 11'b000_0100_0000,
    S_DECIDE   = 11'b000_1000_0000,
    S_FIN_HIT  = 11'b001_0000_0000,
    S_FIN_FULL = 11'b010_0000_0000,
    S_FIN_BUF  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (action_e'(action_i))
            ACT_CODE: begin
              cmd_o.accept_code = 1'b1;
              state_d = sts_i.buf_full ? S_FIN_BUF : S_HASH;
            end
            ACT_PRELOAD: cmd_o.accept_preload = 1'b1;
            ACT_CLEAR: begin
              cmd_o.accept_clear = 1'b1;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        cmd_o.do_hash = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.tab_read = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.ent_valid) begin
          state_d = S_FIN_HIT;
        end else begin
          cmd_o.ctx_init = 1'b1;
          state_d = S_CTX;
        end
      end
      S_CTX: begin
        cmd_o.ctx_issue = 1'b1;
        if (sts_i.last_j) state_d = S_CTX_END;
      end
      S_CTX_END: state_d = S_DECIDE;
      S_DECIDE: begin
        if (!sts_i.mism) begin
          state_d = S_FIN_HIT;
        end else if (sts_i.probe_last) begin
          state_d = S_FIN_FULL;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d = S_READ;
        end
      end
      S_FIN_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.finish    = 1'b1;
          cmd_o.fin_found = 1'b1;
          cmd_o.fin_hist  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_hist = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN_BUF: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

@@ sv/cmbp_dp.sv @@
// Datapath: history and table memories, context window, compare pipe, counts, result.
module cmbp_dp #(
  parameter int unsigned BufferBytes  = cmbp_pkg::DefBufferBytes,
  parameter int unsigned TableEntries = cmbp_pkg::DefTableEntries,
  parameter int unsigned ContextBytes = cmbp_pkg::DefContextBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmbp_pkg::cmd_t  cmd_i,
  output cmbp_pkg::sts_t  sts_o,
  input  logic            coded_bit_i,
  input  logic [7:0]      preload_byte_i,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [9:0]      p_right_o,
  output logic [9:0]      p_total_o,
  output logic            context_seen_o,
  output logic            overflow_o
);
  import cmbp_pkg::*;

  localparam int unsigned Pw     = $clog2(BufferBytes);
  localparam int unsigned Tw     = $clog2(TableEntries);
  localparam int unsigned Jw     = $clog2(ContextBytes + 1);
  localparam int unsigned Cw     = (ContextBytes > 1) ? $clog2(ContextBytes) : 1;
  localparam int unsigned Ew     = Pw + 20;
  localparam int unsigned BitLsb = 16;
  localparam int unsigned PosLsb = 19;
  localparam int unsigned ValBit = Pw + 19;

  // Configuration
  logic [31:0] mask_q;
  logic        sat_q;

  // Byte history state
  logic [Pw:0] pos_q;
  logic [2:0]  bit_q;
  logic [7:0]  cur_q;
  logic [7:0]  win_q [ContextBytes];
  logic        cbit_q;

  // Probe state
  logic [Tw-1:0] slot_q;
  logic [Tw:0]   n_q;
  logic [Tw-1:0] clr_q;
  logic [Jw-1:0] j_q;
  logic [Jw-1:0] pj_q;
  logic          pv_q, pneg_q, psame_q, mism_q;

  // Result register
  logic       out_valid_q;
  logic [9:0] p_right_q, p_total_q;
  logic       seen_q, ovf_q;

  // Memory ports
  logic          h_we;
  logic [Pw-1:0] h_waddr, h_raddr;
  logic [7:0]    h_wdata, h_rdata;
  logic          t_we;
  logic [Tw-1:0] t_waddr;
  logic [Ew-1:0] t_wdata, t_rdata;

  cmbp_ram #(.Width(8), .Depth(BufferBytes)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (cmd_i.ctx_issue),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  cmbp_ram #(.Width(Ew), .Depth(TableEntries)) u_tab (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (cmd_i.tab_read),
    .raddr_i (slot_q),
    .rdata_o (t_rdata)
  );

  // Entry fields
  logic          e_val;
  logic [Pw-1:0] e_pos;
  logic [2:0]    e_bit;
  logic [7:0]    e_c0, e_c1;
  assign e_val = t_rdata[ValBit];
  assign e_pos = t_rdata[PosLsb +: Pw];
  assign e_bit = t_rdata[BitLsb +: 3];
  assign e_c0  = e_val ? t_rdata[7:0] : 8'd0;
  assign e_c1  = e_val ? t_rdata[15:8] : 8'd0;

  // Known high bits and first probe slot
  logic [7:0]  known;
  logic [31:0] prod;
  assign known = 8'(KnownBase >> bit_q);
  assign prod  = {21'd0, bit_q, cur_q & known} * HashMult;

  // History address of the entry side, one byte per step
  logic [Pw:0] hdiff;
  assign hdiff   = {1'b0, e_pos} - (Pw+1)'(j_q);
  assign h_raddr = hdiff[Pw-1:0];

  // Compare stage
  logic [5:0] jm1;
  logic [7:0] hv, a0;
  logic       cmp;
  assign jm1 = 6'(pj_q) - 6'd1;
  assign hv  = pneg_q ? 8'd0 : h_rdata;
  assign a0  = psame_q ? cur_q : h_rdata;
  always_comb begin
    if (pj_q == '0) begin
      cmp = (a0 & known) != (cur_q & known);
    end else begin
      cmp = mask_q[jm1[4:0]] && (hv != win_q[jm1[Cw-1:0]]);
    end
  end

  // Count update and result values
  logic [7:0] c_sel, c_oth, c_new, o_new;
  logic       boost;
  logic [8:0] c_sum;
  logic [9:0] pr, pt;
  always_comb begin
    c_sel = cbit_q ? e_c1 : e_c0;
    c_oth = cbit_q ? e_c0 : e_c1;
    boost = (e_c0 == 8'd0) || (e_c1 == 8'd0);
    c_sum = {1'b0, e_c0} + {1'b0, e_c1};
    pr    = boost ? 10'({c_sel, 2'b00}) : {2'b00, c_sel};
    pt    = boost ? 10'({c_sum, 2'b00}) : {1'b0, c_sum};
    c_new = (!sat_q || c_sel != CntMax) ? c_sel + 8'd1 : c_sel;
    o_new = (c_oth > 8'd1) ? (c_oth >> 1) : c_oth;
  end

  logic [7:0] n0, n1;
  assign n0 = cbit_q ? o_new : c_new;
  assign n1 = cbit_q ? c_new : o_new;

  // Table write: clearing pass or entry update
  assign t_we    = cmd_i.clr_step || (cmd_i.finish && cmd_i.fin_found);
  assign t_waddr = cmd_i.clr_step ? clr_q : slot_q;
  assign t_wdata = cmd_i.clr_step ? '0 :
                   {1'b1, (e_val ? e_pos : pos_q[Pw-1:0]), (e_val ? e_bit : bit_q), n1, n0};

  // History write: preload or byte completion
  logic       buf_full;
  logic [7:0] new_cur;
  logic       byte_done, push;
  assign buf_full  = pos_q == (Pw+1)'(BufferBytes);
  assign new_cur   = cbit_q ? (cur_q | (8'h80 >> bit_q)) : (cur_q & ~(8'h80 >> bit_q));
  assign byte_done = cmd_i.finish && cmd_i.fin_hist && (bit_q == 3'd7);
  assign push      = (cmd_i.accept_preload && !buf_full) || byte_done;
  assign h_we      = push;
  assign h_waddr   = pos_q[Pw-1:0];
  assign h_wdata   = cmd_i.accept_preload ? preload_byte_i : new_cur;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      sat_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MASK: mask_q <= cfg_data_i;
        CFG_SAT:  sat_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // History position, partial byte and context window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bit_q <= '0;
      cur_q <= '0;
      for (int k = 0; k < ContextBytes; k++) win_q[k] <= '0;
    end else if (cmd_i.accept_clear) begin
      pos_q <= '0;
      bit_q <= '0;
      cur_q <= '0;
      for (int k = 0; k < ContextBytes; k++) win_q[k] <= '0;
    end else begin
      if (push) begin
        win_q[0] <= h_wdata;
        for (int k = 1; k < ContextBytes; k++) win_q[k] <= win_q[k-1];
        pos_q <= pos_q + 1'b1;
        bit_q <= '0;
        cur_q <= '0;
      end else if (cmd_i.finish && cmd_i.fin_hist) begin
        cur_q <= new_cur;
        bit_q <= bit_q + 3'd1;
      end
    end
  end

  // Probe sequencing and compare pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbit_q  <= 1'b0;
      slot_q  <= '0;
      n_q     <= '0;
      clr_q   <= '0;
      j_q     <= '0;
      pj_q    <= '0;
      pv_q    <= 1'b0;
      pneg_q  <= 1'b0;
      psame_q <= 1'b0;
      mism_q  <= 1'b0;
    end else begin
      if (cmd_i.accept_code) cbit_q <= coded_bit_i;
      if (cmd_i.accept_clear) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.do_hash) begin
        slot_q <= prod[Tw-1:0];
        n_q    <= '0;
      end else if (cmd_i.next_slot) begin
        slot_q <= slot_q + 1'b1;
        n_q    <= n_q + 1'b1;
      end
      if (cmd_i.ctx_init) begin
        j_q <= '0;
      end else if (cmd_i.ctx_issue) begin
        j_q <= j_q + 1'b1;
      end
      pv_q    <= cmd_i.ctx_issue;
      pj_q    <= j_q;
      pneg_q  <= hdiff[Pw];
      psame_q <= ({1'b0, e_pos} == pos_q);
      if (cmd_i.ctx_init) begin
        mism_q <= (e_bit != bit_q);
      end else if (pv_q && cmp) begin
        mism_q <= 1'b1;
      end
    end
  end

  // Result register
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      p_right_q <= cmd_i.fin_found ? pr : 10'd0;
      p_total_q <= cmd_i.fin_found ? pt : 10'd0;
      seen_q    <= cmd_i.fin_found && ((e_c0 != 8'd0) || (e_c1 != 8'd0));
      ovf_q     <= !cmd_i.fin_found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign p_right_o      = p_right_q;
  assign p_total_o      = p_total_q;
  assign context_seen_o = seen_q;
  assign overflow_o     = ovf_q;

  // Status
  assign sts_o.clr_last   = clr_q == '1;
  assign sts_o.buf_full   = buf_full;
  assign sts_o.ent_valid  = e_val;
  assign sts_o.last_j     = j_q == Jw'(ContextBytes);
  assign sts_o.mism       = mism_q;
  assign sts_o.probe_last = n_q == (Tw+1)'(TableEntries - 1);
  assign sts_o.out_free   = out_free;

endmodule

@@ sv/context_model_bit_predictor.sv @@
// Bit predictor top level: one item in work at a time; a held result stalls the finish step.
// Coded bit: hash, then per used probe slot a table read, entry check, CONTEXT_BYTES+1
// history byte compares through one RAM read port, drain and decide, then finish; an
// empty slot goes from the entry check straight to finish. Preload and no-op items are
// taken in the idle state. Reset and clear run a table clearing pass over every entry
// with input stalled; history needs no pass.
module context_model_bit_predictor #(
  parameter int unsigned BUFFER_BYTES  = cmbp_pkg::DefBufferBytes,
  parameter int unsigned TABLE_ENTRIES = cmbp_pkg::DefTableEntries,
  parameter int unsigned CONTEXT_BYTES = cmbp_pkg::DefContextBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic        coded_bit_i,
  input  logic [7:0]  preload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  p_right_o,
  output logic [9:0]  p_total_o,
  output logic        context_seen_o,
  output logic        overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cmbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cmbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmbp_dp #(
    .BufferBytes  (BUFFER_BYTES),
    .TableEntries (TABLE_ENTRIES),
    .ContextBytes (CONTEXT_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .coded_bit_i    (coded_bit_i),
    .preload_byte_i (preload_byte_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .p_right_o      (p_right_o),
    .p_total_o      (p_total_o),
    .context_seen_o (context_seen_o),
    .overflow_o     (overflow_o)
  );

  // A result is loaded only when the output register can take it
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free) else $error("result loaded over a held result");

  // An accepted clear blocks input for the clearing pass
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_CLEAR) |=> in_stall_o)
    else $error("input taken during table clear");

  // A coded bit with room in the buffer cannot finish before the table is probed
  a_code_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == ACT_CODE && !sts.buf_full) |=> !cmd.finish)
    else $error("coded bit finished without a probe");

endmodule

@@ dv/context_model_bit_predictor_tb.sv @@
// Self-checking testbench for the context model bit predictor.
module context_model_bit_predictor_tb;
  import cmbp_pkg::*;

  localparam int unsigned BufBytes   = DefBufferBytes;
  localparam int unsigned TabEntries = DefTableEntries;
  localparam int unsigned CtxBytes   = DefContextBytes;
  localparam int unsigned SettleCyc  = 60;
  localparam int unsigned HoldCyc    = 400;
  localparam int unsigned WatchLimit = 500000;

  typedef struct {
    logic [9:0] p_right;
    logic [9:0] p_total;
    logic       seen;
    logic       ovf;
  } prob_t;

  // Bit counter table with its own history; queues predicted probabilities
  class bit_count_model;
    logic [31:0] mask;
    logic        sat;
    logic [7:0]  hist[BufBytes];
    int unsigned pos;
    int unsigned bidx;
    bit          tab_used[TabEntries];
    int unsigned tab_pos[TabEntries];
    int unsigned tab_bit[TabEntries];
    logic [7:0]  tab_cnt[TabEntries][2];
    prob_t       probs_q[$];
    int unsigned errors;

    function void wipe();
      foreach (hist[i]) hist[i] = '0;
      foreach (tab_used[i]) tab_used[i] = 1'b0;
      pos  = 0;
      bidx = 0;
    endfunction

    function logic [7:0] hist_at(longint idx);
      if (idx < 0 || idx >= BufBytes) return '0;
      return hist[idx];
    endfunction

    // Same bit index, same known bits, same masked history bytes
    function bit same_ctx(int unsigned s, logic [7:0] known);
      if (tab_bit[s] != bidx) return 1'b0;
      if ((hist_at(tab_pos[s]) & known) != (hist_at(pos) & known)) return 1'b0;
      for (int i = 0; i < CtxBytes; i++) begin
        if (mask[i] && hist_at(longint'(tab_pos[s]) - i - 1) != hist_at(longint'(pos) - i - 1))
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void code_bit(logic b);
      prob_t       r;
      logic [7:0]  known;
      logic [31:0] prod;
      int          found;
      int unsigned s;
      logic [7:0]  c0, c1;
      int unsigned boost;
      r = '{p_right: '0, p_total: '0, seen: 1'b0, ovf: 1'b1};
      if (pos >= BufBytes) begin
        probs_q.push_back(r);
        return;
      end
      known = 8'((KnownBase >> bidx) & 16'h00FF);
      prod  = ((bidx << 8) | (hist[pos] & known)) * HashMult;
      found = -1;
      for (int n = 0; n < TabEntries; n++) begin
        s = (prod + n) % TabEntries;
        if (!tab_used[s]) begin
          tab_used[s]   = 1'b1;
          tab_pos[s]    = pos;
          tab_bit[s]    = bidx;
          tab_cnt[s][0] = '0;
          tab_cnt[s][1] = '0;
          found = s;
          break;
        end
        if (same_ctx(s, known)) begin
          found = s;
          break;
        end
      end
      if (found >= 0) begin
        c0    = tab_cnt[found][0];
        c1    = tab_cnt[found][1];
        boost = (c0 == 0 || c1 == 0) ? BoostSh : 0;
        r.p_right = 10'(32'(tab_cnt[found][b]) << boost);
        r.p_total = 10'((32'(c0) + 32'(c1)) << boost);
        r.seen    = (c0 != 0 || c1 != 0);
        r.ovf     = 1'b0;
        if (!sat || tab_cnt[found][b] < CntMax) tab_cnt[found][b] = tab_cnt[found][b] + 8'd1;
        if (tab_cnt[found][!b] > 1) tab_cnt[found][!b] = tab_cnt[found][!b] >> 1;
      end
      hist[pos][7 - bidx] = b;
      bidx++;
      if (bidx >= 8) begin
        bidx = 0;
        pos++;
      end
      probs_q.push_back(r);
    endfunction

    function void accept_item(action_e act, logic b, logic [7:0] pre);
      case (act)
        ACT_CLEAR: wipe();
        ACT_PRELOAD: begin
          if (pos < BufBytes) begin
            hist[pos] = pre;
            pos++;
            bidx = 0;
          end
        end
        ACT_CODE: code_bit(b);
        default: ;
      endcase
    endfunction

    function void check_prob(prob_t got);
      prob_t e;
      if (probs_q.size() == 0) begin
        $error("result with nothing expected: p_right %0d p_total %0d", got.p_right,
               got.p_total);
        errors++;
        return;
      end
      e = probs_q.pop_front();
      if (got.p_right !== e.p_right) begin
        $error("p_right expected %0d got %0d", e.p_right, got.p_right);
        errors++;
      end
      if (got.p_total !== e.p_total) begin
        $error("p_total expected %0d got %0d", e.p_total, got.p_total);
        errors++;
      end
      if (got.seen !== e.seen) begin
        $error("context_seen expected %0d got %0d", e.seen, got.seen);
        errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow expected %0d got %0d", e.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_NOP;
  logic        coded_bit_i = 1'b0;
  logic [7:0]  preload_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  p_right_o;
  logic [9:0]  p_total_o;
  logic        context_seen_o;
  logic        overflow_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_MASK;
  logic [31:0] cfg_data_i = '0;

  bit_count_model model = new();
  int unsigned    send_idle_pct = 10;
  int unsigned    recv_idle_pct = 73;
  bit             hold_req = 1'b0;
  int unsigned    hold_cnt = 0;
  int unsigned    quiet_cyc = 0;

  context_model_bit_predictor uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stall, or one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req    <= 1'b0;
      hold_cnt    <= HoldCyc;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        model.check_prob('{p_right: p_right_o, p_total: p_total_o, seen: context_seen_o,
                           ovf: overflow_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= WatchLimit) begin
        $display("context_model_bit_predictor: mismatch");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  task automatic send(action_e act, logic b, logic [7:0] pre);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    coded_bit_i    <= b;
    preload_byte_i <= pre;
    do @(posedge clk_i); while (in_stall_o);
    model.accept_item(act, b, pre);
  endtask

  // Drain all results, then let the block settle (covers no-result items)
  task automatic drain();
    in_valid_i <= 1'b0;
    while (model.probs_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MASK) model.mask = data;
    else model.sat = data[0];
  endtask

  // A whole byte coded MSB first
  task automatic code_byte(logic [7:0] v);
    for (int i = 7; i >= 0; i--) send(ACT_CODE, v[i], 8'($urandom));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'h00;
      2, 3: return 8'hFF;
      4: return 8'hA5;
      5: return 8'h5A;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly whole bytes from a small alphabet so contexts recur
  task automatic random_items(int unsigned n);
    int unsigned cnt;
    int unsigned r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        code_byte(pick_byte());
        cnt += 8;
      end else if (r < 85) begin
        send(ACT_CODE, 1'($urandom), 8'($urandom));
        cnt++;
      end else if (r < 96) begin
        send(ACT_PRELOAD, 1'($urandom), pick_byte());
        cnt++;
      end else begin
        send(ACT_NOP, 1'($urandom), 8'($urandom));
      end
    end
  endtask

  // One context hit over and over: drives the one count to its limit
  task automatic count_run(int unsigned n);
    repeat (n) begin
      send(ACT_CODE, 1'b1, 8'($urandom));
      send(ACT_PRELOAD, 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    model.mask = '0;
    model.sat  = 1'b1;
    model.wipe();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(CFG_MASK, 32'h0);
    cfg_write(CFG_SAT, 32'h1);

    // Directed: first sight, repeats, preload mid byte, no-op, clear
    send(ACT_CODE, 1'b0, 8'h00);
    send(ACT_CODE, 1'b1, 8'hFF);
    send(ACT_PRELOAD, 1'b0, 8'hFF);
    send(ACT_PRELOAD, 1'b1, 8'h00);
    send(ACT_NOP, 1'b1, 8'hFF);
    send(ACT_CODE, 1'b1, 8'h00);
    send(ACT_CODE, 1'b1, 8'h00);
    send(ACT_CODE, 1'b0, 8'h00);
    send(ACT_PRELOAD, 1'b0, 8'hA5);
    send(ACT_CODE, 1'b1, 8'h00);
    send(ACT_CODE, 1'b0, 8'h00);
    code_byte(8'hFF);
    send(ACT_CLEAR, 1'b0, 8'h00);
    send(ACT_CODE, 1'b1, 8'h00);
    send(ACT_CODE, 1'b0, 8'h00);

    // Saturating counts, with one long receiver hold-off
    hold_req <= 1'b1;
    count_run(270);
    send(ACT_CODE, 1'b0, 8'h00);
    drain();

    // Wrapping counts
    cfg_write(CFG_SAT, 32'h0);
    count_run(270);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 10;
    cfg_write(CFG_MASK, 32'h0000_0001);
    cfg_write(CFG_SAT, 32'h1);
    random_items(200);
    drain();

    cfg_write(CFG_MASK, 32'hFFFF_FFFF);
    cfg_write(CFG_SAT, 32'h0);
    send(ACT_CLEAR, 1'b0, 8'h00);
    random_items(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CFG_MASK, $urandom & $urandom & $urandom);
    cfg_write(CFG_SAT, 32'($urandom_range(0, 1)));
    random_items(150);
    drain();
    cfg_write(CFG_MASK, 32'h8000_0003);
    random_items(100);
    drain();

    // Clear and code one more byte from an empty table
    cfg_write(CFG_MASK, 32'h0);
    send(ACT_CLEAR, 1'b0, 8'h00);
    code_byte(8'hC3);
    drain();

    if (model.errors == 0) begin
      $display("context_model_bit_predictor: match");
    end else begin
      $display("context_model_bit_predictor: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cmbp_pkg.sv
sv/cmbp_ram.sv
sv/cmbp_ctrl.sv
sv/cmbp_dp.sv
sv/context_model_bit_predictor.sv
dv/context_model_bit_predictor_tb.sv
